// ===== hw/rtl/l4_round_robin_server_select_unit_defines.svh =====
// ----------------------------------------------------------------------------
// l4 round robin server select unit: assertion macros
// Immediate-implication and next-cycle-implication checks on clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef L4_ROUND_ROBIN_SERVER_SELECT_UNIT_DEFINES_SVH
`define L4_ROUND_ROBIN_SERVER_SELECT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define L4RR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("l4rr assertion failed");
`define L4RR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("l4rr assertion failed");
`else
`define L4RR_ASSERT_IMPL(label, ante, cons)
`define L4RR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/l4rr_pkg.sv =====
// ----------------------------------------------------------------------------
// l4rr_pkg
// Shared types and codes of the l4 round robin server select unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package l4rr_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD_KEY    = 2'd0,
    MODE_LOAD_SERVER = 2'd1,
    MODE_NEW_CONN    = 2'd2,
    MODE_AGED        = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_FORWARD   = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_WRITTEN   = 2'd2,
    ST_RELEASED  = 2'd3
  } status_t;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAN_PORT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAN_PORT = 1'd1;
  localparam logic [CFG_DATA_W-1:0] WAN_PORT_RST = 3'd1;
  localparam logic [CFG_DATA_W-1:0] LAN_PORT_RST = 3'd0;

  // real server entry: ip in the upper bits, port in the lower
  localparam int SRV_W = 48;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  arrival_port;
    logic [2:0]  slot;
    logic [2:0]  server_index;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [7:0]  protocol;
    logic [3:0]  server_total;
    logic [31:0] real_ip;
    logic [15:0] real_port;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  egress_port;
    logic [2:0]  chosen_index;
    logic [31:0] chosen_ip;
    logic [15:0] chosen_port;
    logic [31:0] active_count;
  } out_item_t;

  typedef struct packed {
    logic       vld;
    status_t    status;
    logic [2:0] egress;
    logic [2:0] index;
    logic       upd;
    logic       inc;
  } ctrl_t;

endpackage

// ===== hw/rtl/l4rr_ram.sv =====
// ----------------------------------------------------------------------------
// l4rr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module l4rr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/l4rr_select.sv =====
// ----------------------------------------------------------------------------
// l4rr_select
// Service table, key match, round robin pick and table loads (first stage).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module l4rr_select #(
  parameter int SERVICES = 8,
  parameter int SERVERS_PER_SERVICE = 8,
  localparam int DEPTH = SERVICES * SERVERS_PER_SERVICE,
  localparam int FLAT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int SLOT_W = (SERVICES > 1) ? $clog2(SERVICES) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_vld_i,
  input  l4rr_pkg::in_item_t         req_i,
  input  logic [2:0]                 wan_port_i,
  input  logic [2:0]                 lan_port_i,
  output logic                       srv_we_o,
  output logic [FLAT_W-1:0]          srv_waddr_o,
  output logic [l4rr_pkg::SRV_W-1:0] srv_wdata_o,
  output logic [FLAT_W-1:0]          rd_addr_o,
  output logic                       clr_en_o,
  output logic [SLOT_W-1:0]          clr_row_o,
  output l4rr_pkg::ctrl_t            ctrl_o,
  output logic [FLAT_W-1:0]          addr_o
);

  localparam int PTR_W = (SERVERS_PER_SERVICE > 1) ? $clog2(SERVERS_PER_SERVICE) : 1;
  localparam int CNT_W = $clog2(SERVERS_PER_SERVICE + 1);

  logic              key_vld_r   [SERVICES];
  logic [31:0]       key_ip_r    [SERVICES];
  logic [15:0]       key_port_r  [SERVICES];
  logic [7:0]        key_proto_r [SERVICES];
  logic [CNT_W-1:0]  cnt_r       [SERVICES];
  logic [PTR_W-1:0]  rr_r        [SERVICES];

  logic              hit_found;
  logic [SLOT_W-1:0] hit_slot;
  logic [CNT_W-1:0]  hit_cnt;
  logic [PTR_W-1:0]  hit_rr;
  logic [PTR_W-1:0]  pick;
  logic [PTR_W:0]    pick_inc;
  logic [PTR_W-1:0]  rr_adv;
  logic              slot_ok;
  logic              sidx_ok;
  logic              aged_ok;
  logic [SLOT_W-1:0] slot_idx;
  logic [PTR_W-1:0]  sidx_ptr;
  logic [CNT_W-1:0]  total_sat;
  logic              key_we;
  logic              rr_we;
  l4rr_pkg::ctrl_t   ctrl_nxt;
  l4rr_pkg::ctrl_t   ctrl_r;
  logic [FLAT_W-1:0] addr_r;

  function automatic logic [FLAT_W-1:0] flat_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [PTR_W-1:0] idx);
    flat_addr = FLAT_W'(32'(s) * SERVERS_PER_SERVICE + 32'(idx));
  endfunction

  // lowest enabled slot that matches the key
  always_comb begin
    hit_found = 1'b0;
    hit_slot  = '0;
    for (int i = SERVICES - 1; i >= 0; i--) begin
      if (key_vld_r[i] && (cnt_r[i] != '0) && (key_ip_r[i] == req_i.dest_ip) &&
          (key_port_r[i] == req_i.dest_port) && (key_proto_r[i] == req_i.protocol)) begin
        hit_found = 1'b1;
        hit_slot  = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    hit_cnt   = cnt_r[hit_slot];
    hit_rr    = rr_r[hit_slot];
    // stale pointer falls back to server 0
    pick      = ((PTR_W + 1)'(hit_rr) >= (PTR_W + 1)'(hit_cnt)) ? '0 : hit_rr;
    pick_inc  = (PTR_W + 1)'(pick) + (PTR_W + 1)'(1);
    rr_adv    = (pick_inc >= (PTR_W + 1)'(hit_cnt)) ? '0 : PTR_W'(pick_inc);
    slot_ok   = 32'(req_i.slot) < SERVICES;
    sidx_ok   = 32'(req_i.server_index) < SERVERS_PER_SERVICE;
    aged_ok   = hit_found && (32'(req_i.server_index) < 32'(hit_cnt));
    slot_idx  = SLOT_W'(req_i.slot);
    sidx_ptr  = PTR_W'(req_i.server_index);
    total_sat = (32'(req_i.server_total) > SERVERS_PER_SERVICE) ?
                CNT_W'(SERVERS_PER_SERVICE) : CNT_W'(req_i.server_total);
  end

  always_comb begin
    ctrl_nxt        = '0;
    ctrl_nxt.vld    = req_vld_i;
    ctrl_nxt.status = l4rr_pkg::ST_NOT_FOUND;
    key_we          = 1'b0;
    rr_we           = 1'b0;
    srv_we_o        = 1'b0;
    rd_addr_o       = flat_addr(hit_slot, pick);
    case (req_i.mode)
      l4rr_pkg::MODE_LOAD_KEY: begin
        ctrl_nxt.status = l4rr_pkg::ST_WRITTEN;
        key_we          = req_vld_i && slot_ok;
      end
      l4rr_pkg::MODE_LOAD_SERVER: begin
        ctrl_nxt.status = l4rr_pkg::ST_WRITTEN;
        srv_we_o        = req_vld_i && slot_ok && sidx_ok;
      end
      l4rr_pkg::MODE_NEW_CONN: begin
        if ((req_i.arrival_port == wan_port_i) && hit_found) begin
          ctrl_nxt.status = l4rr_pkg::ST_FORWARD;
          ctrl_nxt.egress = lan_port_i;
          ctrl_nxt.index  = 3'(pick);
          ctrl_nxt.upd    = 1'b1;
          ctrl_nxt.inc    = 1'b1;
          rr_we           = req_vld_i;
        end
      end
      l4rr_pkg::MODE_AGED: begin
        if (aged_ok) begin
          ctrl_nxt.status = l4rr_pkg::ST_RELEASED;
          ctrl_nxt.index  = req_i.server_index;
          ctrl_nxt.upd    = 1'b1;
          rd_addr_o       = flat_addr(hit_slot, sidx_ptr);
        end
      end
      default: begin
      end
    endcase
  end

  assign srv_waddr_o = flat_addr(slot_idx, sidx_ptr);
  assign srv_wdata_o = {req_i.real_ip, req_i.real_port};
  assign clr_en_o    = key_we;
  assign clr_row_o   = slot_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SERVICES; i++) begin
        key_vld_r[i] <= 1'b0;
        cnt_r[i]     <= '0;
        rr_r[i]      <= '0;
      end
      ctrl_r <= '0;
    end else begin
      if (key_we) begin
        key_vld_r[slot_idx] <= 1'b1;
        cnt_r[slot_idx]     <= total_sat;
        rr_r[slot_idx]      <= '0;
      end
      if (rr_we) begin
        rr_r[hit_slot] <= rr_adv;
      end
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_ip_r[slot_idx]    <= req_i.dest_ip;
      key_port_r[slot_idx]  <= req_i.dest_port;
      key_proto_r[slot_idx] <= req_i.protocol;
    end
    addr_r <= rd_addr_o;
  end

  assign ctrl_o = ctrl_r;
  assign addr_o = addr_r;

endmodule

// ===== hw/rtl/l4rr_count.sv =====
// ----------------------------------------------------------------------------
// l4rr_count
// Active connection count update with forwarding, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "l4_round_robin_server_select_unit_defines.svh"

module l4rr_count #(
  parameter int SERVICES = 8,
  parameter int SERVERS_PER_SERVICE = 8,
  parameter int COUNT_WIDTH = 32,
  localparam int DEPTH = SERVICES * SERVERS_PER_SERVICE,
  localparam int FLAT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int SLOT_W = (SERVICES > 1) ? $clog2(SERVICES) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  l4rr_pkg::ctrl_t            ctrl_i,
  input  logic [FLAT_W-1:0]          addr_i,
  input  logic [FLAT_W-1:0]          rd_addr_i,
  input  logic                       clr_en_i,
  input  logic [SLOT_W-1:0]          clr_row_i,
  input  logic [COUNT_WIDTH-1:0]     act_rdata_i,
  input  logic [l4rr_pkg::SRV_W-1:0] srv_rdata_i,
  output logic                       act_we_o,
  output logic [FLAT_W-1:0]          act_waddr_o,
  output logic [COUNT_WIDTH-1:0]     act_wdata_o,
  output logic                       out_strobe_o,
  output l4rr_pkg::out_item_t        out_item_o
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   ent_vld_r   [DEPTH];
  logic                   ent_vld_nxt [DEPTH];
  logic                   ent_hit_r;
  logic                   fwd_vld_r;
  logic [FLAT_W-1:0]      fwd_addr_r;
  logic [COUNT_WIDTH-1:0] fwd_data_r;
  logic                   do_upd;
  logic [COUNT_WIDTH-1:0] base;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic                   out_strobe_r;
  l4rr_pkg::out_item_t    out_item_nxt;
  l4rr_pkg::out_item_t    out_item_r;

  assign do_upd = ctrl_i.vld && ctrl_i.upd;

  // the request one ahead wrote this entry while it was being read
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == addr_i)) begin
      base = fwd_data_r;
    end else if (ent_hit_r) begin
      base = act_rdata_i;
    end else begin
      base = '0;
    end
    if (ctrl_i.inc) begin
      cnt_new = (base == COUNT_MAX) ? base : base + COUNT_WIDTH'(1);
    end else begin
      cnt_new = (base == '0) ? base : base - COUNT_WIDTH'(1);
    end
  end

  // key load clears the row after any earlier update of the same cycle
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_vld_nxt[i] = ent_vld_r[i];
    end
    if (do_upd) begin
      ent_vld_nxt[addr_i] = 1'b1;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (clr_en_i && (32'(i / SERVERS_PER_SERVICE) == 32'(clr_row_i))) begin
        ent_vld_nxt[i] = 1'b0;
      end
    end
  end

  always_comb begin
    out_item_nxt              = '0;
    out_item_nxt.status       = ctrl_i.status;
    out_item_nxt.egress_port  = ctrl_i.egress;
    out_item_nxt.chosen_index = ctrl_i.index;
    if (ctrl_i.upd) begin
      out_item_nxt.chosen_ip    = srv_rdata_i[47:16];
      out_item_nxt.chosen_port  = srv_rdata_i[15:0];
      out_item_nxt.active_count = 32'(cnt_new);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        ent_vld_r[i] <= 1'b0;
      end
      fwd_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        ent_vld_r[i] <= ent_vld_nxt[i];
      end
      fwd_vld_r    <= do_upd;
      out_strobe_r <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    ent_hit_r  <= ent_vld_r[rd_addr_i];
    fwd_addr_r <= addr_i;
    fwd_data_r <= cnt_new;
    out_item_r <= out_item_nxt;
  end

  assign act_we_o     = do_upd;
  assign act_waddr_o  = addr_i;
  assign act_wdata_o  = cnt_new;
  assign out_strobe_o = out_strobe_r;
  assign out_item_o   = out_item_r;

  `L4RR_ASSERT_NEXT(a_result_follows_request, ctrl_i.vld, out_strobe_o)
  `L4RR_ASSERT_IMPL(a_release_below_max, do_upd && !ctrl_i.inc, cnt_new != COUNT_MAX)
  `L4RR_ASSERT_IMPL(a_update_only_on_hit, act_we_o, (ctrl_i.status == l4rr_pkg::ST_FORWARD) || (ctrl_i.status == l4rr_pkg::ST_RELEASED))

endmodule

// ===== hw/rtl/l4_round_robin_server_select_unit.sv =====
// ----------------------------------------------------------------------------
// l4_round_robin_server_select_unit
// Layer-4 virtual service match with round robin real server selection.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; busy is
//   always low, so one request can be taken in every cycle.
//   in_item carries the request; its mode selects key load, server load, new
//   connection or aged connection.
//   Each request gives exactly one result on out_item, marked by out_strobe for
//   one cycle, in request order. The receiver cannot stall: results must be
//   taken as they appear.
//   A request passes the input register, then the select stage register along
//   with the registered read of the server and count memories, and then the
//   count update and the result register that drives out_strobe and out_item.
//   Throughput: one request per cycle; back-to-back updates of the same server
//   count are forwarded past the memory.
//   cfg_we writes wan_port (index 0) or lan_port (index 1) from cfg_wdata.
//   Reset: synchronous on rst_n low; clears the service table, round robin
//   pointers, active counts (through per-entry valid bits) and the pipeline;
//   wan_port returns to 1 and lan_port to 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "l4_round_robin_server_select_unit_defines.svh"

module l4_round_robin_server_select_unit #(
  parameter int SERVICES = 8,
  parameter int SERVERS_PER_SERVICE = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  l4rr_pkg::in_item_t                  in_item,
  output logic                                out_strobe,
  output l4rr_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [l4rr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [l4rr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int DEPTH = SERVICES * SERVERS_PER_SERVICE;
  localparam int FLAT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = (SERVICES > 1) ? $clog2(SERVICES) : 1;

  logic                       in_vld_r;
  l4rr_pkg::in_item_t         in_data_r;
  logic [2:0]                 wan_port_r;
  logic [2:0]                 lan_port_r;

  logic                       srv_we;
  logic [FLAT_W-1:0]          srv_waddr;
  logic [l4rr_pkg::SRV_W-1:0] srv_wdata;
  logic [l4rr_pkg::SRV_W-1:0] srv_rdata;
  logic [FLAT_W-1:0]          rd_addr;
  logic                       clr_en;
  logic [SLOT_W-1:0]          clr_row;
  l4rr_pkg::ctrl_t            ctrl;
  logic [FLAT_W-1:0]          addr;
  logic                       act_we;
  logic [FLAT_W-1:0]          act_waddr;
  logic [COUNT_WIDTH-1:0]     act_wdata;
  logic [COUNT_WIDTH-1:0]     act_rdata;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      wan_port_r <= l4rr_pkg::WAN_PORT_RST;
      lan_port_r <= l4rr_pkg::LAN_PORT_RST;
    end else begin
      in_vld_r <= start && !busy;
      if (cfg_we) begin
        case (cfg_index)
          l4rr_pkg::CFG_WAN_PORT: wan_port_r <= cfg_wdata;
          l4rr_pkg::CFG_LAN_PORT: lan_port_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_data_r <= in_item;
    end
  end

  l4rr_select #(
    .SERVICES            (SERVICES),
    .SERVERS_PER_SERVICE (SERVERS_PER_SERVICE)
  ) u_select (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_vld_i   (in_vld_r),
    .req_i       (in_data_r),
    .wan_port_i  (wan_port_r),
    .lan_port_i  (lan_port_r),
    .srv_we_o    (srv_we),
    .srv_waddr_o (srv_waddr),
    .srv_wdata_o (srv_wdata),
    .rd_addr_o   (rd_addr),
    .clr_en_o    (clr_en),
    .clr_row_o   (clr_row),
    .ctrl_o      (ctrl),
    .addr_o      (addr)
  );

  l4rr_ram #(
    .WIDTH (l4rr_pkg::SRV_W),
    .DEPTH (DEPTH)
  ) u_server_ram (
    .clk   (clk),
    .we    (srv_we),
    .waddr (srv_waddr),
    .wdata (srv_wdata),
    .raddr (rd_addr),
    .rdata (srv_rdata)
  );

  l4rr_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (act_wdata),
    .raddr (rd_addr),
    .rdata (act_rdata)
  );

  l4rr_count #(
    .SERVICES            (SERVICES),
    .SERVERS_PER_SERVICE (SERVERS_PER_SERVICE),
    .COUNT_WIDTH         (COUNT_WIDTH)
  ) u_count (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl_i       (ctrl),
    .addr_i       (addr),
    .rd_addr_i    (rd_addr),
    .clr_en_i     (clr_en),
    .clr_row_i    (clr_row),
    .act_rdata_i  (act_rdata),
    .srv_rdata_i  (srv_rdata),
    .act_we_o     (act_we),
    .act_waddr_o  (act_waddr),
    .act_wdata_o  (act_wdata),
    .out_strobe_o (out_strobe),
    .out_item_o   (out_item)
  );

  `L4RR_ASSERT_IMPL(a_result_has_request, out_strobe, $past(start && !busy, 3))
  `L4RR_ASSERT_IMPL(a_idle_fields_zero, out_strobe && ((out_item.status == l4rr_pkg::ST_NOT_FOUND) || (out_item.status == l4rr_pkg::ST_WRITTEN)), (out_item.chosen_ip == '0) && (out_item.active_count == '0) && (out_item.egress_port == '0))

endmodule
